@@ rtl/core/wpws_pkg.sv @@
// Shared types and constants for the wheel pulse window speed unit.
package wpws_pkg;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned DIV_STEPS    = 16;
  localparam int unsigned SPEED_SCALE  = 36;
  localparam int unsigned SPEED_SHIFT  = 8;

  localparam logic [15:0] MAX_GAP_MS          = 16'd2000;
  localparam logic [15:0] COUNTER_MAX_RESET   = 16'd1023;
  localparam logic [15:0] TOOTH_LENGTH_RESET  = 16'd0;
  localparam logic [15:0] SPEED_SATURATED     = 16'hFFFF;

  localparam logic CFG_IDX_COUNTER_MAX  = 1'b0;
  localparam logic CFG_IDX_TOOTH_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_SCALE,
    ST_START,
    ST_DIV,
    ST_OUT
  } wpws_state_e;

  typedef struct packed {
    logic        clear;
    logic        rd;
    logic        upd;
    logic [15:0] dc;
    logic [15:0] dt;
  } wpws_ring_req_t;

endpackage

@@ rtl/core/wpws_ring.sv @@
// Delta ring memories with per-entry valid bits and running window sums.
module wpws_ring #(
  parameter int unsigned WINDOW_DEPTH = wpws_pkg::WINDOW_DEPTH,
  parameter int unsigned AW           = 3,
  parameter int unsigned SW           = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wpws_pkg::wpws_ring_req_t req_i,
  input  logic [AW-1:0]           addr_i,
  output logic [SW-1:0]           sum_c_o,
  output logic [SW-1:0]           sum_t_o
);

  logic [15:0]             mem_c [WINDOW_DEPTH];
  logic [15:0]             mem_t [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] valid_q;
  logic [AW-1:0]           addr_q;
  logic                    rd_vld_q;
  logic [15:0]             rd_c_q;
  logic [15:0]             rd_t_q;
  logic [SW-1:0]           sum_c_q;
  logic [SW-1:0]           sum_t_q;
  logic [15:0]             old_c;
  logic [15:0]             old_t;

  assign old_c   = rd_vld_q ? rd_c_q : 16'd0;
  assign old_t   = rd_vld_q ? rd_t_q : 16'd0;
  assign sum_c_o = sum_c_q;
  assign sum_t_o = sum_t_q;

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_c_q <= mem_c[addr_i];
      rd_t_q <= mem_t[addr_i];
    end
    if (req_i.upd) begin
      mem_c[addr_q] <= req_i.dc;
      mem_t[addr_q] <= req_i.dt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      sum_c_q  <= '0;
      sum_t_q  <= '0;
    end else if (req_i.clear) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      sum_c_q  <= '0;
      sum_t_q  <= '0;
    end else begin
      if (req_i.rd) begin
        addr_q   <= addr_i;
        rd_vld_q <= valid_q[addr_i];
      end
      if (req_i.upd) begin
        valid_q[addr_q] <= 1'b1;
        sum_c_q <= sum_c_q - SW'(old_c) + SW'(req_i.dc);
        sum_t_q <= sum_t_q - SW'(old_t) + SW'(req_i.dt);
      end
    end
  end

endmodule

@@ rtl/core/wpws_div.sv @@
// Saturating 16-bit restoring divider, one quotient bit per cycle.
module wpws_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned TW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [TW-1:0] divisor_i,
  output logic          done_o,
  output logic [15:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(wpws_pkg::DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TW-1:0]    den_q;
  logic [TW-1:0]    rem_q;
  logic [15:0]      quot_q;
  logic [TW-1:0]    hi;
  logic             sat;
  logic [TW:0]      shifted;
  logic             ge;
  logic [TW:0]      diff;

  assign hi      = TW'(dividend_i[DW-1:16]);
  assign sat     = hi >= divisor_i;
  assign shifted = {rem_q, quot_q[15]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(wpws_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      if (sat) begin
        quot_q <= wpws_pkg::SPEED_SATURATED;
      end else begin
        rem_q  <= hi;
        quot_q <= dividend_i[15:0];
      end
    end else if (busy_q) begin
      rem_q  <= ge ? diff[TW-1:0] : shifted[TW-1:0];
      quot_q <= {quot_q[14:0], ge};
    end
  end

endmodule

@@ rtl/core/wheel_pulse_window_speed_unit.sv @@
// Wheel pulse window speed unit: delta ring, window sums and serial speed divide.
// Repeated stamps, priming and gaps go from acceptance straight to the output state;
//   a computed speed passes update, multiply, scale, divider start and a 16-step
//   serial divide (cut short on saturation). Input is accepted only in idle; the
//   result register lets the next transaction in while a result waits downstream.
// Reset: asynchronous, clears valid bits and sums at once; no clearing pass.
module wheel_pulse_window_speed_unit #(
  parameter int unsigned WINDOW_DEPTH = wpws_pkg::WINDOW_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] pulse_count, [31:16] time_stamp
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] speed
  output logic [0:0]  m_axis_tuser,   // [0] speed_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SW = wpws_pkg::FIELD_W + AW;
  localparam int unsigned PW = SW + wpws_pkg::FIELD_W;
  localparam int unsigned NW = PW + 6;
  localparam int unsigned DW = NW - wpws_pkg::SPEED_SHIFT;

  wpws_pkg::wpws_state_e   state_q, state_d;
  wpws_pkg::wpws_ring_req_t ring_req;

  logic [15:0]   counter_max_q, tooth_length_q;
  logic          priming_q;
  logic [15:0]   prev_count_q, prev_stamp_q;
  logic [AW-1:0] pos_q, pos_next;
  logic [15:0]   held_speed_q;
  logic          held_valid_q;
  logic [15:0]   res_speed_q;
  logic          res_valid_q;
  logic [15:0]   dc_q, dt_q;
  logic [PW-1:0] prod_q;
  logic [DW-1:0] dividend_q;
  logic          m_vld_q;
  logic [15:0]   m_speed_q;
  logic          m_valid_flag_q;

  logic          acc_in;
  logic [15:0]   in_count, in_stamp, dt, dc;
  logic          same, gap;
  logic [SW-1:0] sum_c, sum_t, divisor;
  logic          div_start, div_done;
  logic [15:0]   quot;
  logic          out_load;
  logic          cfg_wr;

  assign in_count = s_axis_tdata[15:0];
  assign in_stamp = s_axis_tdata[31:16];
  assign acc_in   = s_axis_tvalid && s_axis_tready;
  assign same     = in_stamp == prev_stamp_q;
  assign dt       = in_stamp - prev_stamp_q;
  assign gap      = dt > wpws_pkg::MAX_GAP_MS;
  assign dc       = (in_count >= prev_count_q) ? (in_count - prev_count_q)
                  : (16'd1 + in_count + counter_max_q - prev_count_q);
  assign pos_next = (pos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign divisor  = (sum_t == '0) ? SW'(1) : sum_t;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      wpws_pkg::CFG_IDX_COUNTER_MAX:  prdata = {16'd0, counter_max_q};
      wpws_pkg::CFG_IDX_TOOTH_LENGTH: prdata = {16'd0, tooth_length_q};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_max_q  <= wpws_pkg::COUNTER_MAX_RESET;
      tooth_length_q <= wpws_pkg::TOOTH_LENGTH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        wpws_pkg::CFG_IDX_COUNTER_MAX:  counter_max_q  <= pwdata[15:0];
        wpws_pkg::CFG_IDX_TOOTH_LENGTH: tooth_length_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  wpws_ring #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .AW          (AW),
    .SW          (SW)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .addr_i (pos_next),
    .sum_c_o(sum_c),
    .sum_t_o(sum_t)
  );

  wpws_div #(
    .DW(DW),
    .TW(SW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend_q),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ring_req      = '0;
    ring_req.dc   = dc_q;
    ring_req.dt   = dt_q;
    div_start     = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      wpws_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (same || priming_q) begin
            state_d = wpws_pkg::ST_OUT;
          end else if (gap) begin
            ring_req.clear = 1'b1;
            state_d        = wpws_pkg::ST_OUT;
          end else begin
            ring_req.rd = 1'b1;
            state_d     = wpws_pkg::ST_UPD;
          end
        end
      end
      wpws_pkg::ST_UPD: begin
        ring_req.upd = 1'b1;
        state_d      = wpws_pkg::ST_MUL;
      end
      wpws_pkg::ST_MUL:   state_d = wpws_pkg::ST_SCALE;
      wpws_pkg::ST_SCALE: state_d = wpws_pkg::ST_START;
      wpws_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = wpws_pkg::ST_DIV;
      end
      wpws_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = wpws_pkg::ST_OUT;
        end
      end
      wpws_pkg::ST_OUT: begin
        if (!m_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = wpws_pkg::ST_IDLE;
        end
      end
      default: state_d = wpws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priming_q    <= 1'b1;
      prev_count_q <= '0;
      prev_stamp_q <= '0;
      pos_q        <= AW'(WINDOW_DEPTH - 1);
      held_speed_q <= '0;
      held_valid_q <= 1'b0;
      res_speed_q  <= '0;
      res_valid_q  <= 1'b0;
    end else if (state_q == wpws_pkg::ST_IDLE && acc_in) begin
      if (same) begin
        res_speed_q <= held_speed_q;
        res_valid_q <= held_valid_q;
      end else if (priming_q) begin
        prev_count_q <= in_count;
        prev_stamp_q <= in_stamp;
        priming_q    <= 1'b0;
        res_speed_q  <= '0;
        res_valid_q  <= 1'b0;
      end else if (gap) begin
        pos_q        <= AW'(WINDOW_DEPTH - 1);
        prev_count_q <= '0;
        prev_stamp_q <= '0;
        priming_q    <= 1'b1;
        held_speed_q <= '0;
        held_valid_q <= 1'b0;
        res_speed_q  <= '0;
        res_valid_q  <= 1'b0;
      end else begin
        pos_q        <= pos_next;
        prev_count_q <= in_count;
        prev_stamp_q <= in_stamp;
      end
    end else if (state_q == wpws_pkg::ST_DIV && div_done) begin
      res_speed_q  <= quot;
      res_valid_q  <= 1'b1;
      held_speed_q <= quot;
      held_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == wpws_pkg::ST_IDLE && acc_in) begin
      dc_q <= dc;
      dt_q <= dt;
    end
    if (state_q == wpws_pkg::ST_MUL) begin
      prod_q <= PW'(sum_c) * PW'(tooth_length_q);
    end
    if (state_q == wpws_pkg::ST_SCALE) begin
      dividend_q <= DW'((NW'(prod_q) * NW'(wpws_pkg::SPEED_SCALE)) >> wpws_pkg::SPEED_SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_speed_q      <= res_speed_q;
      m_valid_flag_q <= res_valid_q;
    end
  end

  assign m_axis_tvalid   = m_vld_q;
  assign m_axis_tdata    = m_speed_q;
  assign m_axis_tuser[0] = m_valid_flag_q;

  a_upd_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.upd |-> $past(ring_req.rd))
    else $error("ring update without preceding read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_vld_q || m_axis_tready))
    else $error("result register overwritten");

  a_held_not_priming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> !priming_q)
    else $error("held speed valid while priming");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == wpws_pkg::ST_DIV))
    else $error("divider finished outside divide state");

endmodule

@@ tb/wheel_pulse_window_speed_unit_test.sv @@
// Self-checking testbench for the wheel pulse window speed unit.
module wheel_pulse_window_speed_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] speed;
    logic        valid;
  } speed_result_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] stamp;
    logic        typed;
    logic [15:0] speed;
    logic        valid;
  } probe_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] pulse_count, [31:16] time_stamp
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] speed
  logic [0:0]  m_axis_tuser;        // [0] speed_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wheel_pulse_window_speed_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [15:0] cfg_counter_max = wpws_pkg::COUNTER_MAX_RESET;
  logic [15:0] cfg_tooth_length = wpws_pkg::TOOTH_LENGTH_RESET;
  logic [15:0] win_counts [wpws_pkg::WINDOW_DEPTH];
  logic [15:0] win_times [wpws_pkg::WINDOW_DEPTH];
  int unsigned win_pos;
  logic [15:0] last_count;
  logic [15:0] last_stamp;
  logic        awaiting_prime;
  speed_result_t held_result;

  speed_result_t expected_speeds [$];
  int mismatches = 0;
  int n_results = 0;
  int n_held = 0;
  int n_primed = 0;
  int n_gaps = 0;
  int n_saturated = 0;
  int n_computed = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic void restart_window();
    for (int i = 0; i < wpws_pkg::WINDOW_DEPTH; i++) begin
      win_counts[i] = '0;
      win_times[i] = '0;
    end
    win_pos = wpws_pkg::WINDOW_DEPTH - 1;
    last_count = '0;
    last_stamp = '0;
    awaiting_prime = 1'b1;
    held_result = '0;
  endfunction

  function automatic speed_result_t estimate_speed(logic [15:0] count, logic [15:0] stamp);
    speed_result_t res;
    logic [15:0] dt;
    logic [15:0] dc;
    int unsigned sum_c;
    int unsigned sum_t;
    longint unsigned quo;
    res = '0;
    if (stamp == last_stamp) begin
      res = held_result;
      n_held++;
    end else if (awaiting_prime) begin
      last_count = count;
      last_stamp = stamp;
      awaiting_prime = 1'b0;
      n_primed++;
    end else begin
      dt = stamp - last_stamp;
      win_pos = (win_pos + 1 < wpws_pkg::WINDOW_DEPTH) ? win_pos + 1 : 0;
      last_stamp = stamp;
      if (dt > wpws_pkg::MAX_GAP_MS) begin
        restart_window();
        n_gaps++;
      end else begin
        if (count >= last_count) dc = count - last_count;
        else dc = 16'(32'd1 + 32'(count) + 32'(cfg_counter_max) - 32'(last_count));
        win_counts[win_pos] = dc;
        win_times[win_pos] = dt;
        last_count = count;
        sum_c = 0;
        sum_t = 0;
        for (int i = 0; i < wpws_pkg::WINDOW_DEPTH; i++) begin
          sum_c += win_counts[i];
          sum_t += win_times[i];
        end
        if (sum_t == 0) sum_t = 1;
        quo = (64'(sum_c) * 64'(cfg_tooth_length) * wpws_pkg::SPEED_SCALE) /
              (64'(sum_t) << wpws_pkg::SPEED_SHIFT);
        if (quo > 64'(wpws_pkg::SPEED_SATURATED)) begin
          res.speed = wpws_pkg::SPEED_SATURATED;
          n_saturated++;
        end else begin
          res.speed = quo[15:0];
        end
        res.valid = 1'b1;
        held_result = res;
        n_computed++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_speeds.size() == 0) begin
        report_mismatch("unexpected result, speed", m_axis_tdata, -1);
      end else begin
        speed_result_t want;
        want = expected_speeds.pop_front();
        if (m_axis_tdata !== want.speed) report_mismatch("speed", m_axis_tdata, want.speed);
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("speed_valid", m_axis_tuser[0], want.valid);
      end
    end
  end

  // Drive the output handshake; honor a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_register(logic idx, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == wpws_pkg::CFG_IDX_COUNTER_MAX) cfg_counter_max = value;
    else if (idx == wpws_pkg::CFG_IDX_TOOTH_LENGTH) cfg_tooth_length = value;
  endtask

  task automatic send_sample(logic [15:0] count, logic [15:0] stamp, logic typed,
                             speed_result_t typed_result);
    speed_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {stamp, count};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = estimate_speed(count, stamp);
    expected_speeds.push_back(typed ? typed_result : pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  probe_row_t probe_rows [0:17] = '{
    '{16'd5,     16'd0,     1'b1, 16'd0,     1'b0},  // unchanged stamp before priming
    '{16'd100,   16'd10,    1'b1, 16'd0,     1'b0},  // prime
    '{16'd100,   16'd10,    1'b1, 16'd0,     1'b0},  // repeat while nothing computed
    '{16'd110,   16'd20,    1'b0, 16'd0,     1'b0},
    '{16'd110,   16'd20,    1'b0, 16'd0,     1'b0},  // repeat of a computed speed
    '{16'd1020,  16'd30,    1'b0, 16'd0,     1'b0},
    '{16'd3,     16'd40,    1'b0, 16'd0,     1'b0},  // counter wrap
    '{16'hFFFF,  16'd50,    1'b0, 16'd0,     1'b0},  // count above counter maximum
    '{16'd0,     16'd60,    1'b0, 16'd0,     1'b0},
    '{16'd0,     16'd2061,  1'b1, 16'd0,     1'b0},  // gap of 2001 ms
    '{16'd0,     16'd0,     1'b1, 16'd0,     1'b0},  // stamp equals cleared stamp
    '{16'd7,     16'hFFFF,  1'b1, 16'd0,     1'b0},  // prime at top stamp
    '{16'd8,     16'd1999,  1'b0, 16'd0,     1'b0},  // gap of exactly 2000 ms, kept
    '{16'd8,     16'd4000,  1'b1, 16'd0,     1'b0},  // gap of 2001 ms
    '{16'hFFFF,  16'd1,     1'b1, 16'd0,     1'b0},  // prime
    '{16'hFFFF,  16'd2,     1'b1, 16'd0,     1'b1},  // zero count delta
    '{16'd0,     16'd3,     1'b0, 16'd0,     1'b0},
    '{16'hFFFF,  16'd4,     1'b1, 16'hFFFF,  1'b1}   // saturated speed
  };

  int unsigned phase_cmax [6] = '{1023, 65535, 1, 0, 4000, 300};
  int unsigned phase_tooth [6] = '{0, 65535, 1, 16'h0A00, 16'h0180, 16'h4000};
  int phase_idle [6] = '{0, 74, 0, 7, 0, 7};
  int phase_stall [6] = '{0, 0, 74, 7, 0, 7};
  int phase_items [6] = '{200, 250, 250, 200, 300, 300};

  initial begin
    int unsigned cur_count;
    logic [15:0] cur_stamp;
    logic [15:0] count;
    int unsigned cmax;
    int r;
    restart_window();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_register(wpws_pkg::CFG_IDX_COUNTER_MAX, 16'd1023);
    write_register(wpws_pkg::CFG_IDX_TOOTH_LENGTH, 16'h0100);
    foreach (probe_rows[i])
      send_sample(probe_rows[i].count, probe_rows[i].stamp, probe_rows[i].typed,
                  '{speed: probe_rows[i].speed, valid: probe_rows[i].valid});
    drain();

    cur_count = 16'hFFFF;
    cur_stamp = 16'd4;
    for (int p = 0; p < 6; p++) begin
      if (p >= 4) begin
        phase_cmax[p] = $urandom_range(1, 65535);
        phase_tooth[p] = $urandom_range(0, 65535);
      end
      write_register(wpws_pkg::CFG_IDX_COUNTER_MAX, phase_cmax[p][15:0]);
      write_register(wpws_pkg::CFG_IDX_TOOTH_LENGTH, phase_tooth[p][15:0]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      if (p == 2) hold_off = 400;
      cmax = phase_cmax[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          if ($urandom_range(0, 1)) cur_count = $urandom_range(0, 65535);
        end else if (r < 12) begin
          cur_stamp = cur_stamp + 16'($urandom_range(2001, 5000));
          cur_count = $urandom_range(0, 65535);
        end else if (r < 17) begin
          cur_count = $urandom_range(0, 65535);
          cur_stamp = 16'($urandom);
        end else if (r < 20) begin
          cur_stamp = cur_stamp + ($urandom_range(0, 1) ? 16'd2000 : 16'd2001);
          cur_count = (cur_count + $urandom_range(0, 50)) % (cmax + 1);
        end else begin
          cur_stamp = cur_stamp + 16'($urandom_range(0, 9) == 0 ?
                                      $urandom_range(1, 2000) : $urandom_range(1, 60));
          if ($urandom_range(0, 19) == 0)
            cur_count = (cur_count + $urandom_range(0, cmax)) % (cmax + 1);
          else
            cur_count = (cur_count + $urandom_range(0, 40)) % (cmax + 1);
        end
        count = cur_count[15:0];
        send_sample(count, cur_stamp, 1'b0, '0);
      end
      drain();
    end

    mismatches += expected_speeds.size();
    $display("Covered %0d results: %0d computed, %0d saturated, %0d held, %0d primings,",
             n_results, n_computed, n_saturated, n_held, n_primed);
    $display("  %0d long-gap clears, over 7 register settings and 4 flow-control mixes.",
             n_gaps);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
